>>> sv/sbfi_pkg.sv
// shared constants and face tables for the segment box face intersect core
package sbfi_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // 1 / eps^2 with eps = 1e-5
    localparam int EPS_W = 34;
    localparam logic [EPS_W-1:0] EPS_INV_SQ = 34'd10000000000;

    localparam int NUM_FACES = 6;

    // face codes, in test order
    localparam logic [2:0] FACE_ZMAX = 3'd0;
    localparam logic [2:0] FACE_XMAX = 3'd1;
    localparam logic [2:0] FACE_ZMIN = 3'd2;
    localparam logic [2:0] FACE_XMIN = 3'd3;
    localparam logic [2:0] FACE_YMIN = 3'd4;
    localparam logic [2:0] FACE_YMAX = 3'd5;
    localparam logic [2:0] FACE_LAST = FACE_YMAX;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    function automatic logic [1:0] face_axis(input logic [2:0] f);
        logic [1:0] a;
        unique case (f)
            FACE_ZMAX, FACE_ZMIN: a = AXIS_Z;
            FACE_XMAX, FACE_XMIN: a = AXIS_X;
            default:              a = AXIS_Y;
        endcase
        return a;
    endfunction

    function automatic logic face_is_max(input logic [2:0] f);
        return (f == FACE_ZMAX) || (f == FACE_XMAX) || (f == FACE_YMAX);
    endfunction

    // the two axes other than a, in increasing order
    function automatic logic [1:0] other_axis(input logic [1:0] a, input logic k);
        logic [1:0] o;
        unique case (a)
            AXIS_X:  o = k ? AXIS_Z : AXIS_Y;
            AXIS_Y:  o = k ? AXIS_Z : AXIS_X;
            default: o = k ? AXIS_Y : AXIS_X;
        endcase
        return o;
    endfunction

endpackage

>>> sv/segment_box_face_intersect_core.sv
// segment against axis-aligned box face crossing, pipelined core
//
// One request carries a segment (start, end) and box bounds, all signed fixed
// point of COORD_WIDTH bits; the binary point does not matter since every
// value shares one format. The six face planes are tested in the order zmax,
// xmax, zmin, xmin, ymin, ymax; a face is skipped when the segment is near
// parallel to it (axis component squared at most 1e-10 of the length squared),
// else the crossing fraction must lie in (0, 1] and the exact crossing point
// inside the box, bounds inclusive. The first such face is reported with its
// point, other coordinates rounded to nearest (ties away from zero) and
// saturated. With no hit, face and point read zero. Throughput is one request
// per clock unless the result side stalls; the crossing point comes from a
// restoring divider that yields one quotient bit per stage. A stall on
// the result side freezes the whole pipeline, nothing is lost or repeated.
module segment_box_face_intersect_core #(
    parameter int COORD_WIDTH = sbfi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_x_min,
    input  logic signed [COORD_WIDTH-1:0] i_box_x_max,
    input  logic signed [COORD_WIDTH-1:0] i_box_y_min,
    input  logic signed [COORD_WIDTH-1:0] i_box_y_max,
    input  logic signed [COORD_WIDTH-1:0] i_box_z_min,
    input  logic signed [COORD_WIDTH-1:0] i_box_z_max,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [2:0]                    o_face,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y,
    output logic signed [COORD_WIDTH-1:0] o_hit_z
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW;          // square of a magnitude
    localparam int SW = 2 * CW + 2;      // sum of three squares
    localparam int OW = 2 * CW + 3;      // cross products for the inside test
    localparam int EW = sbfi_pkg::EPS_W;
    localparam int XW = 2 * CW + EW;     // scaled axis square
    localparam int NF = sbfi_pkg::NUM_FACES;

    typedef struct packed {
        logic                hit;
        logic [2:0]          face;
        logic [1:0]          axis;
        logic [CW-1:0]       plane;
        logic [2:0][CW-1:0]  p0;
        logic [2:0]          dneg;
        logic [CW-1:0]       den;
    } t_ctx;

    // whole pipeline advances together, held while the result waits
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: direction and bounds
    logic                 r1_v;
    logic signed [CW-1:0] r1_p0   [3];
    logic signed [CW:0]   r1_d    [3];
    logic signed [CW-1:0] r1_bmin [3];
    logic signed [CW-1:0] r1_bmax [3];

    // stage 2: magnitudes, squares, numerators
    logic                 r2_v;
    logic signed [CW-1:0] r2_p0   [3];
    logic signed [CW:0]   r2_d    [3];
    logic [CW-1:0]        r2_dmag [3];
    logic [PW-1:0]        r2_sq   [3];
    logic signed [CW+1:0] r2_num  [NF];
    logic [NF-1:0]        r2_plane_ok;
    logic signed [CW:0]   r2_loff [3];
    logic signed [CW:0]   r2_hoff [3];
    logic signed [CW-1:0] r2_bmin [3];
    logic signed [CW-1:0] r2_bmax [3];

    // stage 3: products
    logic                 r3_v;
    logic [SW-1:0]        r3_sum;
    logic [CW+EW-1:0]     r3_pl   [3];
    logic [CW+EW-1:0]     r3_ph   [3];
    logic [NF-1:0]        r3_num_ok;
    logic [NF-1:0]        r3_plane_ok;
    logic signed [OW-1:0] r3_off  [NF][2];
    logic signed [OW-1:0] r3_lo   [3][2];
    logic signed [OW-1:0] r3_hi   [3][2];
    logic signed [CW-1:0] r3_p0   [3];
    logic signed [CW:0]   r3_d    [3];
    logic [CW-1:0]        r3_dmag [3];
    logic signed [CW+1:0] r3_num  [NF];
    logic signed [CW-1:0] r3_bmin [3];
    logic signed [CW-1:0] r3_bmax [3];

    // stage 4: compares
    logic                 r4_v;
    logic [2:0]           r4_nonpar;
    logic [NF-1:0]        r4_ok;
    logic signed [CW-1:0] r4_p0   [3];
    logic signed [CW:0]   r4_d    [3];
    logic [CW-1:0]        r4_dmag [3];
    logic signed [CW+1:0] r4_num  [NF];
    logic signed [CW-1:0] r4_bmin [3];
    logic signed [CW-1:0] r4_bmax [3];

    // stage 5: face chosen
    logic                 r5_v;
    t_ctx                 r5_ctx;
    logic [CW-1:0]        r5_dmag [3];
    logic [CW-1:0]        r5_num;

    // divider line, index 0 loaded with the dividend
    logic                 r_dv   [CW+1];
    t_ctx                 r_dctx [CW+1];
    logic [CW-1:0]        r_rem  [CW+1][3];
    logic [CW-1:0]        r_low  [CW+1][3];
    logic [CW-1:0]        r_q    [CW+1][3];

    logic [CW-1:0]        n_rem  [CW][3];
    logic [CW-1:0]        n_q    [CW][3];

    // stage 1 inputs
    logic signed [CW-1:0] in_p0 [3];
    logic signed [CW-1:0] in_p1 [3];
    logic signed [CW-1:0] in_bmin [3];
    logic signed [CW-1:0] in_bmax [3];

    always_comb begin
        in_p0[0] = i_start_x; in_p0[1] = i_start_y; in_p0[2] = i_start_z;
        in_p1[0] = i_end_x;   in_p1[1] = i_end_y;   in_p1[2] = i_end_z;
        in_bmin[0] = i_box_x_min; in_bmin[1] = i_box_y_min; in_bmin[2] = i_box_z_min;
        in_bmax[0] = i_box_x_max; in_bmax[1] = i_box_y_max; in_bmax[2] = i_box_z_max;
    end

    // stage 2 logic
    logic [CW-1:0]        n2_dmag  [3];
    logic signed [CW+1:0] n2_num   [NF];
    logic [NF-1:0]        n2_plane_ok;

    always_comb begin
        logic [1:0]           a;
        logic signed [CW-1:0] pl;
        logic signed [CW+1:0] raw;
        for (int i = 0; i < 3; i++) begin
            n2_dmag[i] = r1_d[i][CW] ? CW'(-r1_d[i]) : r1_d[i][CW-1:0];
        end
        for (int f = 0; f < NF; f++) begin
            a   = sbfi_pkg::face_axis(3'(f));
            pl  = sbfi_pkg::face_is_max(3'(f)) ? r1_bmax[a] : r1_bmin[a];
            raw = (CW+2)'(pl) - (CW+2)'(r1_p0[a]);
            n2_num[f]      = r1_d[a][CW] ? -raw : raw;
            n2_plane_ok[f] = (pl >= r1_bmin[a]) && (pl <= r1_bmax[a]);
        end
    end

    // stage 3 logic
    logic [NF-1:0]        n3_num_ok;
    logic signed [OW-1:0] n3_off [NF][2];
    logic signed [OW-1:0] n3_lo  [3][2];
    logic signed [OW-1:0] n3_hi  [3][2];

    always_comb begin
        logic [1:0]          a;
        logic [1:0]          o;
        logic signed [CW:0]  den_s;
        for (int f = 0; f < NF; f++) begin
            a = sbfi_pkg::face_axis(3'(f));
            n3_num_ok[f] = (r2_num[f] > 0) &&
                           (r2_num[f] <= $signed({2'b00, r2_dmag[a]}));
            for (int k = 0; k < 2; k++) begin
                o = sbfi_pkg::other_axis(a, k[0]);
                n3_off[f][k] = OW'(r2_d[o]) * OW'(r2_num[f]);
            end
        end
        for (int ax = 0; ax < 3; ax++) begin
            den_s = $signed({1'b0, r2_dmag[ax]});
            for (int k = 0; k < 2; k++) begin
                o = sbfi_pkg::other_axis(2'(ax), k[0]);
                n3_lo[ax][k] = OW'(r2_loff[o]) * OW'(den_s);
                n3_hi[ax][k] = OW'(r2_hoff[o]) * OW'(den_s);
            end
        end
    end

    // stage 4 logic
    logic [2:0]    n4_nonpar;
    logic [NF-1:0] n4_ok;

    always_comb begin
        logic [XW-1:0] scaled;
        logic [1:0]    a;
        logic          ins;
        for (int ax = 0; ax < 3; ax++) begin
            scaled = (XW'(r3_ph[ax]) << CW) + XW'(r3_pl[ax]);
            n4_nonpar[ax] = scaled > XW'(r3_sum);
        end
        for (int f = 0; f < NF; f++) begin
            a   = sbfi_pkg::face_axis(3'(f));
            ins = 1'b1;
            for (int k = 0; k < 2; k++) begin
                if (r3_lo[a][k] > r3_off[f][k] || r3_off[f][k] > r3_hi[a][k]) begin
                    ins = 1'b0;
                end
            end
            n4_ok[f] = r3_num_ok[f] && r3_plane_ok[f] && ins;
        end
    end

    // stage 5 logic: lowest qualifying face wins
    t_ctx          n5_ctx;
    logic [CW-1:0] n5_num;

    always_comb begin
        logic [1:0] a;
        n5_ctx = '0;
        n5_num = '0;
        for (int i = 0; i < 3; i++) begin
            n5_ctx.p0[i]   = r4_p0[i];
            n5_ctx.dneg[i] = r4_d[i][CW];
        end
        for (int f = NF - 1; f >= 0; f--) begin
            a = sbfi_pkg::face_axis(3'(f));
            if (r4_ok[f] && r4_nonpar[a]) begin
                n5_ctx.hit   = 1'b1;
                n5_ctx.face  = 3'(f);
                n5_ctx.axis  = a;
                n5_ctx.plane = sbfi_pkg::face_is_max(3'(f)) ? r4_bmax[a] : r4_bmin[a];
                n5_ctx.den   = r4_dmag[a];
                n5_num       = r4_num[f][CW-1:0];
            end
        end
    end

    // divider steps, one quotient bit each
    always_comb begin
        logic [CW:0] trial;
        for (int j = 0; j < CW; j++) begin
            for (int l = 0; l < 3; l++) begin
                trial = {r_rem[j][l], r_low[j][l][CW-1]};
                if (trial >= {1'b0, r_dctx[j].den}) begin
                    n_rem[j][l] = CW'(trial - {1'b0, r_dctx[j].den});
                    n_q[j][l]   = {r_q[j][l][CW-2:0], 1'b1};
                end else begin
                    n_rem[j][l] = trial[CW-1:0];
                    n_q[j][l]   = {r_q[j][l][CW-2:0], 1'b0};
                end
            end
        end
    end

    // rounding, sign and saturation
    logic signed [CW-1:0] n_pt [3];

    always_comb begin
        logic          rnd;
        logic [CW:0]   qm;
        logic signed [CW+1:0] pt;
        t_ctx          c;
        c = r_dctx[CW];
        for (int l = 0; l < 3; l++) begin
            rnd = {r_rem[CW][l], 1'b0} >= {1'b0, c.den};
            qm  = {1'b0, r_q[CW][l]} + (CW+1)'(rnd);
            pt  = (CW+2)'($signed(c.p0[l]));
            pt  = c.dneg[l] ? pt - $signed({1'b0, qm}) : pt + $signed({1'b0, qm});
            if (pt > $signed((CW+2)'({1'b0, {(CW-1){1'b1}}}))) begin
                n_pt[l] = {1'b0, {(CW-1){1'b1}}};
            end else if (pt < -$signed((CW+2)'({1'b1, {(CW-1){1'b0}}}))) begin
                n_pt[l] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_pt[l] = pt[CW-1:0];
            end
            if (!c.hit) begin
                n_pt[l] = '0;
            end else if (2'(l) == c.axis) begin
                n_pt[l] = c.plane;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            for (int j = 0; j <= CW; j++) r_dv[j] <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r1_v  <= i_in_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r_dv[0] <= r5_v;
            for (int j = 0; j < CW; j++) r_dv[j+1] <= r_dv[j];
            o_out_valid <= r_dv[CW];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p0[i]   <= in_p0[i];
                r1_d[i]    <= (CW+1)'(in_p1[i]) - (CW+1)'(in_p0[i]);
                r1_bmin[i] <= in_bmin[i];
                r1_bmax[i] <= in_bmax[i];

                r2_p0[i]   <= r1_p0[i];
                r2_d[i]    <= r1_d[i];
                r2_dmag[i] <= n2_dmag[i];
                r2_sq[i]   <= n2_dmag[i] * n2_dmag[i];
                r2_loff[i] <= (CW+1)'(r1_bmin[i]) - (CW+1)'(r1_p0[i]);
                r2_hoff[i] <= (CW+1)'(r1_bmax[i]) - (CW+1)'(r1_p0[i]);
                r2_bmin[i] <= r1_bmin[i];
                r2_bmax[i] <= r1_bmax[i];

                r3_pl[i]   <= r2_sq[i][CW-1:0] * sbfi_pkg::EPS_INV_SQ;
                r3_ph[i]   <= r2_sq[i][PW-1:CW] * sbfi_pkg::EPS_INV_SQ;
                r3_p0[i]   <= r2_p0[i];
                r3_d[i]    <= r2_d[i];
                r3_dmag[i] <= r2_dmag[i];
                r3_bmin[i] <= r2_bmin[i];
                r3_bmax[i] <= r2_bmax[i];
                for (int k = 0; k < 2; k++) begin
                    r3_lo[i][k] <= n3_lo[i][k];
                    r3_hi[i][k] <= n3_hi[i][k];
                end

                r4_p0[i]   <= r3_p0[i];
                r4_d[i]    <= r3_d[i];
                r4_dmag[i] <= r3_dmag[i];
                r4_bmin[i] <= r3_bmin[i];
                r4_bmax[i] <= r3_bmax[i];

                r5_dmag[i] <= r4_dmag[i];
            end
            r2_num      <= n2_num;
            r2_plane_ok <= n2_plane_ok;
            r3_sum      <= SW'(r2_sq[0]) + SW'(r2_sq[1]) + SW'(r2_sq[2]);
            r3_num_ok   <= n3_num_ok;
            r3_plane_ok <= r2_plane_ok;
            r3_num      <= r2_num;
            for (int f = 0; f < NF; f++) begin
                for (int k = 0; k < 2; k++) r3_off[f][k] <= n3_off[f][k];
            end
            r4_nonpar <= n4_nonpar;
            r4_ok     <= n4_ok;
            r4_num    <= r3_num;
            r5_ctx    <= n5_ctx;
            r5_num    <= n5_num;

            // dividend |d| * num, below den << CW since num <= den
            r_dctx[0] <= r5_ctx;
            for (int l = 0; l < 3; l++) begin
                {r_rem[0][l], r_low[0][l]} <= r5_dmag[l] * r5_num;
                r_q[0][l] <= '0;
            end
            for (int j = 0; j < CW; j++) begin
                r_dctx[j+1] <= r_dctx[j];
                for (int l = 0; l < 3; l++) begin
                    r_rem[j+1][l] <= n_rem[j][l];
                    r_low[j+1][l] <= {r_low[j][l][CW-2:0], 1'b0};
                    r_q[j+1][l]   <= n_q[j][l];
                end
            end

            o_hit   <= r_dctx[CW].hit;
            o_face  <= r_dctx[CW].hit ? r_dctx[CW].face : sbfi_pkg::FACE_ZMAX;
            o_hit_x <= n_pt[0];
            o_hit_y <= n_pt[1];
            o_hit_z <= n_pt[2];
        end
    end

    // checks
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_face <= sbfi_pkg::FACE_LAST)
        else $error("face code out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_face == sbfi_pkg::FACE_ZMAX &&
            o_hit_x == '0 && o_hit_y == '0 && o_hit_z == '0)
        else $error("miss result not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r1_v)
        else $error("pipeline not empty after reset");

    a_hit_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_v && r5_ctx.hit |-> r5_ctx.den != '0 && r5_num <= r5_ctx.den)
        else $error("hit with bad divisor");

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the segment box face intersect core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = 32;
    localparam int RAND_ITEMS  = 500;
    localparam int LATENCY     = CW + 7;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [127:0]  t_wide;

    // one request: start, end, box lower and upper bounds, indexed x y z
    typedef struct {
        t_coord s [3];
        t_coord e [3];
        t_coord lo [3];
        t_coord hi [3];
    } t_seg_req;

    typedef struct {
        logic       hit;
        logic [2:0] face;
        t_coord     pt [3];
    } t_crossing;

    typedef struct {
        t_seg_req  req;
        logic      typed;
        t_crossing want;
    } t_stim_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    t_coord i_start_x = '0, i_start_y = '0, i_start_z = '0;
    t_coord i_end_x = '0, i_end_y = '0, i_end_z = '0;
    t_coord i_box_x_min = '0, i_box_x_max = '0, i_box_y_min = '0;
    t_coord i_box_y_max = '0, i_box_z_min = '0, i_box_z_max = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    logic   o_hit;
    logic [2:0] o_face;
    t_coord o_hit_x, o_hit_y, o_hit_z;

    segment_box_face_intersect_core #(.COORD_WIDTH(CW)) DUT (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    t_crossing crossings_due [$];
    t_stim_row directed_rows [$];
    int        fail_count = 0;
    int        results_seen = 0;
    int        requests_taken = 0;

    // axis tested by each face code
    function automatic int axis_of(input logic [2:0] f);
        case (f)
            sbfi_pkg::FACE_ZMAX, sbfi_pkg::FACE_ZMIN: return 2;
            sbfi_pkg::FACE_XMAX, sbfi_pkg::FACE_XMIN: return 0;
            default:                                  return 1;
        endcase
    endfunction

    function automatic logic upper_face(input logic [2:0] f);
        return f == sbfi_pkg::FACE_ZMAX || f == sbfi_pkg::FACE_XMAX ||
               f == sbfi_pkg::FACE_YMAX;
    endfunction

    // exact rational crossing test, first qualifying face wins
    function automatic t_crossing predict_crossing(input t_seg_req r);
        t_crossing res;
        t_wide p0 [3], d [3], lo_b [3], hi_b [3], pt [3];
        t_wide sum, limit, plane, num, den, off, lo, hi, mg, q, rem;
        int a;
        logic in_box;
        logic done;
        logic [2:0] f;
        res.hit = 1'b0;
        res.face = sbfi_pkg::FACE_ZMAX;
        res.pt[0] = '0; res.pt[1] = '0; res.pt[2] = '0;
        sum = 0;
        done = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p0[i] = r.s[i];
            d[i] = t_wide'(r.e[i]) - p0[i];
            lo_b[i] = r.lo[i];
            hi_b[i] = r.hi[i];
            sum += d[i] * d[i];
        end
        limit = sum / t_wide'(sbfi_pkg::EPS_INV_SQ);
        for (int k = 0; k < sbfi_pkg::NUM_FACES; k++) begin
            f = 3'(k);
            a = axis_of(f);
            plane = upper_face(f) ? hi_b[a] : lo_b[a];
            if (done || d[a] * d[a] <= limit) continue;
            num = plane - p0[a];
            den = d[a];
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            if (!(num > 0 && num <= den)) continue;
            if (plane < lo_b[a] || plane > hi_b[a]) continue;
            in_box = 1'b1;
            for (int i = 0; i < 3; i++) begin
                if (i == a) begin
                    pt[i] = plane;
                end else if (in_box) begin
                    off = d[i] * num;
                    lo = (lo_b[i] - p0[i]) * den;
                    hi = (hi_b[i] - p0[i]) * den;
                    if (lo > off || off > hi) begin
                        in_box = 1'b0;
                    end else begin
                        mg = (d[i] < 0 ? -d[i] : d[i]) * num;
                        q = mg / den;
                        rem = mg % den;
                        // round to nearest, ties away from zero
                        if (2 * rem >= den) q = q + 1;
                        pt[i] = p0[i] + (d[i] < 0 ? -q : q);
                    end
                end
            end
            if (!in_box) continue;
            res.hit = 1'b1;
            res.face = f;
            for (int i = 0; i < 3; i++) begin
                if (pt[i] > t_wide'(32'sh7fffffff)) res.pt[i] = 32'sh7fffffff;
                else if (pt[i] < -t_wide'(64'sh80000000)) res.pt[i] = 32'sh80000000;
                else res.pt[i] = t_coord'(pt[i]);
            end
            done = 1'b1;
        end
        return res;
    endfunction

    function automatic t_seg_req mk_req(input int sx, sy, sz, ex, ey, ez,
                                        x0, x1, y0, y1, z0, z1);
        t_seg_req r;
        r.s[0] = sx; r.s[1] = sy; r.s[2] = sz;
        r.e[0] = ex; r.e[1] = ey; r.e[2] = ez;
        r.lo[0] = x0; r.hi[0] = x1;
        r.lo[1] = y0; r.hi[1] = y1;
        r.lo[2] = z0; r.hi[2] = z1;
        return r;
    endfunction

    function automatic t_crossing mk_hit(input logic h, input logic [2:0] f,
                                         input int x, y, z);
        t_crossing c;
        c.hit = h; c.face = f;
        c.pt[0] = x; c.pt[1] = y; c.pt[2] = z;
        return c;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 0;
            3: return $urandom_range(0, 3) - 2;
            default: return $urandom;
        endcase
    endfunction

    // mostly boxes with segments poking through them, plus noise
    function automatic t_seg_req random_req();
        t_seg_req r;
        int mode, c, h, span, t;
        mode = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (mode < 15) begin
                r.s[i] = $urandom; r.e[i] = $urandom;
                r.lo[i] = $urandom; r.hi[i] = $urandom;
            end else if (mode < 25) begin
                r.s[i] = pick_extreme(); r.e[i] = pick_extreme();
                r.lo[i] = pick_extreme(); r.hi[i] = pick_extreme();
            end else begin
                c = $signed($urandom) >>> 4;
                h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << 22);
                span = 3 * h + 4;
                r.lo[i] = c - h;
                r.hi[i] = c + h;
                r.s[i] = c + $signed($urandom_range(0, 2 * span)) - span;
                r.e[i] = c + $signed($urandom_range(0, 2 * span)) - span;
                // near parallel along this axis
                if ($urandom_range(0, 9) == 0) r.e[i] = r.s[i] + $urandom_range(0, 3) - 1;
                // end on a plane exactly
                if ($urandom_range(0, 9) == 0) r.e[i] = $urandom_range(0, 1) ? r.hi[i] : r.lo[i];
                // broken box
                if ($urandom_range(0, 19) == 0) begin
                    t = r.lo[i]; r.lo[i] = r.hi[i] + 1; r.hi[i] = t;
                end
            end
        end
        return r;
    endfunction

    task automatic put_req(input t_seg_req r);
        i_start_x <= r.s[0]; i_start_y <= r.s[1]; i_start_z <= r.s[2];
        i_end_x <= r.e[0]; i_end_y <= r.e[1]; i_end_z <= r.e[2];
        i_box_x_min <= r.lo[0]; i_box_x_max <= r.hi[0];
        i_box_y_min <= r.lo[1]; i_box_y_max <= r.hi[1];
        i_box_z_min <= r.lo[2]; i_box_z_max <= r.hi[2];
    endtask

    function automatic logic quiet_phase(input int n);
        return n >= 250 && n < 380;
    endfunction

    // append one row to the directed table
    task automatic add_row(input t_stim_row row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // directed stimulus; U is one unit in Q16.16
    localparam int U = 65536;
    initial begin
        t_stim_row row;
        // zero-length segment never hits
        row.req = mk_req(U, U, U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        row.typed = 1; row.want = mk_hit(0, sbfi_pkg::FACE_ZMAX, 0, 0, 0);
        add_row(row);
        // inverted box never hits
        row.req = mk_req(-U, U, U, 3*U, U, U, 2*U, 0, 0, 2*U, 0, 2*U);
        row.typed = 1; row.want = mk_hit(0, sbfi_pkg::FACE_ZMAX, 0, 0, 0);
        add_row(row);
        // straight down through the top face
        row.req = mk_req(U, U, 3*U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        row.typed = 1; row.want = mk_hit(1, sbfi_pkg::FACE_ZMAX, U, U, 2*U);
        add_row(row);
        // in through the upper x face
        row.req = mk_req(3*U, U, U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        row.typed = 1; row.want = mk_hit(1, sbfi_pkg::FACE_XMAX, 2*U, U, U);
        add_row(row);
        row.typed = 0;
        // lower z, lower x, lower y, upper y, slanted
        row.req = mk_req(U, U, -U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        row.req = mk_req(-U, U, U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        row.req = mk_req(U, -U, U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        row.req = mk_req(U, 3*U, U, U, U, U, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        row.req = mk_req(-U, 7, 5*U/2, U+3, 2*U-1, 1, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        // end exactly on a plane, start exactly on a plane
        row.req = mk_req(U, U, 5*U, U, U, 2*U, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        row.req = mk_req(U, U, 2*U, U, U, 5*U, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        // near parallel to z
        row.req = mk_req(-U, U, U, 3*U, U, U+1, 0, 2*U, 0, 2*U, 0, 2*U);
        add_row(row);
        // flat box
        row.req = mk_req(U, U, 3*U, U, U, -U, 0, 2*U, 0, 2*U, U, U);
        add_row(row);
        // full range extremes
        row.req = mk_req(32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                         32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_row(row);
        row.req = mk_req(32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, -1, 32'sh7fffffff,
                         -U, U, -U, U, -U, U);
        add_row(row);
        row.req = mk_req(-1, -1, -1, -1, -1, -1, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 0, 0);
        add_row(row);
        row.req = mk_req(0, 32'sh7fffffff, 0, 0, 32'sh80000000, 0,
                         -1, 1, 32'sh80000000, 32'sh7fffffff, -1, 1);
        add_row(row);
    end

    // request side
    initial begin
        int issued;
        int total;
        t_crossing cur_want;
        logic cur_typed;
        t_seg_req cur_req;
        issued = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        total = directed_rows.size() + RAND_ITEMS;
        while (requests_taken < total) begin
            @(posedge i_clk);
            if (i_in_valid && o_in_ready) begin
                crossings_due.insert(crossings_due.size(),
                                     cur_typed ? cur_want : predict_crossing(cur_req));
                requests_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (issued == total ||
                    (!quiet_phase(issued) && $urandom_range(0, 99) < 36)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    if (issued < directed_rows.size()) begin
                        cur_req = directed_rows[issued].req;
                        cur_typed = directed_rows[issued].typed;
                        cur_want = directed_rows[issued].want;
                    end else begin
                        cur_req = random_req();
                        cur_typed = 1'b0;
                    end
                    put_req(cur_req);
                    i_in_valid <= 1'b1;
                    issued++;
                end
            end
        end
        // drain the pipeline, then allow a latency's worth of quiet
        while (crossings_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side: random back-pressure, one long hold so the input stalls
    int  hold_left = 0;
    logic held_once = 1'b0;
    always @(posedge i_clk) begin
        t_crossing want;
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (crossings_due.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = crossings_due.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    fail_count++;
                end
                if (o_face !== want.face) begin
                    $error("face: expected %0d, got %0d", want.face, o_face);
                    fail_count++;
                end
                if (o_hit_x !== want.pt[0]) begin
                    $error("hit_x: expected %0d, got %0d", want.pt[0], o_hit_x);
                    fail_count++;
                end
                if (o_hit_y !== want.pt[1]) begin
                    $error("hit_y: expected %0d, got %0d", want.pt[1], o_hit_y);
                    fail_count++;
                end
                if (o_hit_z !== want.pt[2]) begin
                    $error("hit_z: expected %0d, got %0d", want.pt[2], o_hit_z);
                    fail_count++;
                end
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!held_once && results_seen >= 100) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_phase(results_seen) || ($urandom_range(0, 99) >= 36);
        end
    end

    // watchdog
    initial begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
